/* rtl/tgps_pkg.sv */
// Package for the two-tap grain pitch shifter: field widths, register codes,
// reset values, multiplier sizing and the Hann window table.
// No dependencies.
package tgps_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int FRAC_W     = 16;
	localparam int STEP_W     = 17;
	localparam int GRAIN_W    = 12;
	localparam int PSCALE_W   = 16;
	localparam int MIX_W      = 16;
	localparam int DELAY_W    = GRAIN_W + FRAC_W;
	localparam int PHASE_W    = 16;
	localparam int WGT_W      = 16;
	localparam int WIN_W      = 9;
	localparam int WIN_N      = 1 << WIN_W;
	localparam int DEF_DEPTH_W = 13;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = STEP_W;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAIN_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_SCALE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 2'd3;

	localparam logic [GRAIN_W-1:0]  RST_GRAIN_LEN   = 12'd2160;
	localparam logic [PSCALE_W-1:0] RST_PHASE_SCALE = 16'd30;
	localparam logic [MIX_W-1:0]    MIX_ONE         = 16'd32768;
	localparam int                  MIX_SH          = 15;

	// shared multiplier: signed MUL_A_W x signed MUL_B_W
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 48;
	localparam int LERP_W  = SAMPLE_W + FRAC_W + 2;

	typedef logic [WGT_W-1:0] hann_tab_t [WIN_N];

	// sin^2(pi*k/N) in Q15 from a Q30 Taylor series of sine
	function automatic hann_tab_t build_hann();
		longint    kk, a, a2, term, sum;
		int        k;
		hann_tab_t tab;
		for (k = 0; k < WIN_N; k++) begin
			kk = (2 * k > WIN_N) ? longint'(WIN_N - k) : longint'(k);
			a = 64'sd3373259426 * kk / WIN_N;
			a2 = (a * a) >>> 30;
			term = a;
			sum = a;
			// terms up to the 13th power; each divisor is 2n(2n+1)
			term = -((term * a2) / 64'sd1073741824) / 64'sd6;
			sum = sum + term;
			term = -((term * a2) / 64'sd1073741824) / 64'sd20;
			sum = sum + term;
			term = -((term * a2) / 64'sd1073741824) / 64'sd42;
			sum = sum + term;
			term = -((term * a2) / 64'sd1073741824) / 64'sd72;
			sum = sum + term;
			term = -((term * a2) / 64'sd1073741824) / 64'sd110;
			sum = sum + term;
			term = -((term * a2) / 64'sd1073741824) / 64'sd156;
			sum = sum + term;
			if (sum < 0)
				sum = 0;
			if (sum > 64'sd1073741824)
				sum = 64'sd1073741824;
			tab[k] = WGT_W'((sum * sum + (64'sd1 <<< 44)) >>> 45);
		end
		return tab;
	endfunction

	localparam hann_tab_t HANN_TAB = build_hann();

endpackage

/* rtl/tgps_if.sv */
// Stream channels of the grain pitch shifter: sample in, sample out.
// Valid/ready handshake; depends on tgps_pkg.
interface tgps_in_if import tgps_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface tgps_out_if import tgps_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

/* rtl/two_tap_grain_pitch_shifter.sv */
// Two-tap grain pitch shifter top level: delay memory, sequencer, shared multiplier.
// Depends on tgps_pkg, tgps_if (channels) and tgps_ram (delay memory).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------
//  din     | in  | valid / ready      | sample_in  s16
//  dout    | out | valid / ready      | sample_out s16, saturated
//  wr_*    | in  | wr_en, no back-off | wr_index 2b, wr_data 17b
//
// Each item is taken in the idle state and then worked through 15 sequencer
// steps that share one 33x18 signed multiplier and the single read port of the
// delay memory (two reads per tap for the interpolation).
// No clearing pass after reset: a fill count masks entries not yet written.
// The last step waits while the output register still holds an untaken item;
// din.ready is low for the whole of an item's work.
module two_tap_grain_pitch_shifter import tgps_pkg::*; #(
	parameter int DEPTH_W = DEF_DEPTH_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	tgps_in_if.sink               din,
	tgps_out_if.source            dout
);

	localparam int DEPTH = 1 << DEPTH_W;
	localparam int POS_W = DEPTH_W + FRAC_W;
	localparam int T_W   = DELAY_W + 2;
	localparam int OUT_SH = 2 * MIX_SH;

	localparam logic signed [LERP_W-1:0] LERP_HALF = LERP_W'(1) <<< (FRAC_W - 1);
	localparam logic signed [ACC_W-1:0]  FIN_HALF  = ACC_W'(1) <<< (OUT_SH - 1);
	localparam logic signed [ACC_W-OUT_SH-1:0] Y_MAX =
		(ACC_W-OUT_SH)'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [ACC_W-OUT_SH-1:0] Y_MIN =
		(ACC_W-OUT_SH)'(-(1 << (SAMPLE_W - 1)));

	// sequencer codes
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WRAP = 4'd1;   // wrap tap 1 delay into the grain
	localparam logic [3:0] S_HALF = 4'd2;   // tap 2 sits half a grain on
	localparam logic [3:0] S_RD0  = 4'd3;   // read older sample, phase product
	localparam logic [3:0] S_RD1  = 4'd4;   // read newer sample, window lookup
	localparam logic [3:0] S_LERP = 4'd5;   // (m1 - m0) * frac
	localparam logic [3:0] S_SAMP = 4'd6;   // round interpolated sample
	localparam logic [3:0] S_WGT  = 4'd7;   // sample * window weight
	localparam logic [3:0] S_MIX0 = 4'd8;   // dry * (1 - mix)
	localparam logic [3:0] S_MIX1 = 4'd9;   // wet * mix
	localparam logic [3:0] S_FIN  = 4'd10;  // round, saturate, load output

	// configuration registers
	logic signed [STEP_W-1:0] step_q;
	logic [GRAIN_W-1:0]       grain_q;
	logic [PSCALE_W-1:0]      pscale_q;
	logic [MIX_W-1:0]         mix_q;

	logic [3:0]               state_q;
	logic                     tap_sel_q;
	logic [DEPTH_W-1:0]       wp_q;
	logic [DEPTH_W:0]         fill_q;
	logic signed [SAMPLE_W-1:0] dry_q;
	logic signed [T_W-1:0]    t_q;
	logic [DELAY_W-1:0]       tap_q;
	logic [DELAY_W-1:0]       t2_q;
	logic                     rd_ok_q;
	logic signed [SAMPLE_W-1:0] m0_q;
	logic signed [SAMPLE_W-1:0] s_q;
	logic [WGT_W-1:0]         w_q;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SAMPLE_W-1:0] out_q;
	logic                     out_vld_q;

	logic                     take;
	logic                     out_load;
	logic [DELAY_W-1:0]       g_full;
	logic signed [T_W-1:0]    g_s;
	logic signed [T_W-1:0]    t_sub;
	logic signed [T_W-1:0]    t_add;
	logic signed [T_W-1:0]    t1;
	logic [DELAY_W:0]         t2_sum;
	logic [DELAY_W:0]         t2_new;
	logic [DELAY_W-1:0]       cur_delay;
	logic [POS_W-1:0]         pos;
	logic [DEPTH_W-1:0]       i0;
	logic [FRAC_W-1:0]        frac;
	logic [DEPTH_W-1:0]       raddr;
	logic [SAMPLE_W-1:0]      rdata;
	logic signed [SAMPLE_W-1:0] mem_val;
	logic signed [SAMPLE_W:0] diff;
	logic [MIX_W-1:0]         mix_eff;
	logic                     mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [LERP_W-1:0] lerp_sum;
	logic signed [ACC_W-1:0]  fin_sum;
	logic signed [ACC_W-OUT_SH-1:0] y_full;
	logic signed [SAMPLE_W-1:0] y_sat;

	assign din.ready  = (state_q == S_IDLE);
	assign take       = din.valid && din.ready;
	assign out_load   = (state_q == S_FIN) && (!out_vld_q || dout.ready);
	assign dout.valid = out_vld_q;
	assign dout.sample_out = out_q;

	assign mix_eff = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;

	// ---------------------------------------------------------------
	// configuration writes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			grain_q  <= RST_GRAIN_LEN;
			pscale_q <= RST_PHASE_SCALE;
			mix_q    <= MIX_ONE;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DELAY_STEP:  step_q   <= signed'(wr_data[STEP_W-1:0]);
				REG_GRAIN_LEN:   grain_q  <= wr_data[GRAIN_W-1:0];
				REG_PHASE_SCALE: pscale_q <= wr_data[PSCALE_W-1:0];
				REG_WET_MIX:     mix_q    <= wr_data[MIX_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// tap delay wrap: grain bound G = grain_length in Q16
	// ---------------------------------------------------------------
	assign g_full = {grain_q, {FRAC_W{1'b0}}};
	assign g_s    = signed'(T_W'(g_full));
	assign t_sub  = t_q - g_s;
	assign t_add  = t_q + g_s;

	always_comb begin
		if (t_q >= g_s) begin
			// a lowered grain length can leave us past the bound after one wrap
			t1 = (t_sub >= g_s) ? '0 : t_sub;
		end else if (t_q < 0) begin
			t1 = (t_add < 0) ? '0 : t_add;
		end else begin
			t1 = t_q;
		end
	end

	assign t2_sum = {1'b0, tap_q} + {1'b0, g_full >> 1};

	always_comb begin
		t2_new = (t2_sum >= {1'b0, g_full}) ? (t2_sum - {1'b0, g_full}) : t2_sum;
		if (t2_new >= {1'b0, g_full})
			t2_new = '0;
	end

	// ---------------------------------------------------------------
	// read position: write pointer minus delay, modulo the memory span
	// ---------------------------------------------------------------
	assign cur_delay = tap_sel_q ? t2_q : tap_q;
	assign pos       = {wp_q, {FRAC_W{1'b0}}} - POS_W'(cur_delay);
	assign i0        = pos[POS_W-1:FRAC_W];
	assign frac      = pos[FRAC_W-1:0];
	assign raddr     = (state_q == S_RD1) ? (i0 + 1'b1) : i0;

	tgps_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_dly_ram (
		.clk   (clk),
		.we    (take),
		.waddr (wp_q),
		.wdata (din.sample_in),
		.raddr (raddr),
		.rdata (rdata)
	);

	// entries past the fill count were never written and read as zero
	assign mem_val = rd_ok_q ? signed'(rdata) : '0;
	assign diff    = (SAMPLE_W+1)'(mem_val) - (SAMPLE_W+1)'(m0_q);

	// ---------------------------------------------------------------
	// shared multiplier operand select
	// ---------------------------------------------------------------
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_RD0: begin
				mul_a = signed'(MUL_A_W'(cur_delay));
				mul_b = signed'(MUL_B_W'(pscale_q));
			end
			S_LERP: begin
				mul_a = MUL_A_W'(diff);
				mul_b = signed'(MUL_B_W'(frac));
			end
			S_WGT: begin
				mul_a = MUL_A_W'(s_q);
				mul_b = signed'(MUL_B_W'(w_q));
			end
			S_MIX0: begin
				mul_a = MUL_A_W'(dry_q);
				mul_b = signed'(MUL_B_W'(MIX_ONE - mix_eff));
			end
			S_MIX1: begin
				// wet sum fits 32 bits signed
				mul_a = acc_q[MUL_A_W-1:0];
				mul_b = signed'(MUL_B_W'(mix_eff));
			end
			default: mul_en = 1'b0;
		endcase
	end

	// m0*65536 + (m1-m0)*f, rounded half up
	assign lerp_sum = (LERP_W'(m0_q) <<< FRAC_W) + LERP_W'(prod_q) + LERP_HALF;

	assign fin_sum = acc_q + ACC_W'(prod_q) + FIN_HALF;
	assign y_full  = fin_sum[ACC_W-1:OUT_SH];

	always_comb begin
		if (y_full > Y_MAX)
			y_sat = SAMPLE_W'(Y_MAX);
		else if (y_full < Y_MIN)
			y_sat = SAMPLE_W'(Y_MIN);
		else
			y_sat = y_full[SAMPLE_W-1:0];
	end

	// ---------------------------------------------------------------
	// datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_a * mul_b;
		if (take) begin
			dry_q <= din.sample_in;
			t_q   <= T_W'(signed'({2'b00, tap_q})) + T_W'(step_q);
		end
		if (state_q == S_HALF)
			t2_q <= t2_new[DELAY_W-1:0];
		if (state_q == S_RD1) begin
			m0_q <= mem_val;
			// phase = (delay * scale) >> 16 mod 1; top bits pick the entry
			w_q  <= HANN_TAB[prod_q[FRAC_W+PHASE_W-1 -: WIN_W]];
		end
		if (state_q == S_SAMP)
			s_q <= lerp_sum[FRAC_W +: SAMPLE_W];
		case (state_q)
			S_RD0:  acc_q <= tap_sel_q ? (acc_q + ACC_W'(prod_q)) : '0;
			S_MIX0: acc_q <= acc_q + ACC_W'(prod_q);
			S_MIX1: acc_q <= ACC_W'(prod_q) <<< MIX_SH;
			default: ;
		endcase
		if (out_load)
			out_q <= y_sat;
	end

	// ---------------------------------------------------------------
	// sequencer and control state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tap_sel_q <= 1'b0;
			wp_q      <= '0;
			fill_q    <= '0;
			tap_q     <= '0;
			rd_ok_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_ok_q <= ({1'b0, raddr} < fill_q);
			if (out_load)
				out_vld_q <= 1'b1;
			else if (dout.ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					tap_sel_q <= 1'b0;
					if (take) begin
						state_q <= S_WRAP;
						if (fill_q != (DEPTH_W+1)'(DEPTH))
							fill_q <= fill_q + 1'b1;
					end
				end
				S_WRAP: begin
					tap_q   <= t1[DELAY_W-1:0];
					state_q <= S_HALF;
				end
				S_HALF: state_q <= S_RD0;
				S_RD0:  state_q <= S_RD1;
				S_RD1:  state_q <= S_LERP;
				S_LERP: state_q <= S_SAMP;
				S_SAMP: state_q <= S_WGT;
				S_WGT: begin
					if (tap_sel_q) begin
						state_q <= S_MIX0;
					end else begin
						tap_sel_q <= 1'b1;
						state_q   <= S_RD0;
					end
				end
				S_MIX0: state_q <= S_MIX1;
				S_MIX1: state_q <= S_FIN;
				S_FIN: begin
					if (out_load) begin
						wp_q    <= wp_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> state_q == S_WRAP)
		else $error("item taken but sequencer did not start");

	a_tap1_in_grain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HALF |-> (tap_q < $past(g_full)) || (tap_q == '0))
		else $error("tap 1 delay outside grain after wrap");

	a_tap2_in_grain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD0) && !tap_sel_q |-> (t2_q < $past(g_full)) || (t2_q == '0))
		else $error("tap 2 delay outside grain");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && dout.valid && !dout.ready |=> state_q == S_FIN)
		else $error("result dropped while output register full");

endmodule

/* rtl/tgps_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tgps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
